>>> rtl/dcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance constraint projection package
// Widths, pipeline depths, shared types and the saturation function.
// ----------------------------------------------------------------------------
package dcp_pkg;

   localparam int POS_W       = 32;
   localparam int DIFF_W      = POS_W + 1;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int SUM_W       = SQ_W + 2;
   localparam int LEN_W       = 35;
   localparam int ROOT_STAGES = LEN_W;
   localparam int RAD_W       = 2 * ROOT_STAGES;
   localparam int REM_W       = LEN_W + 2;
   localparam int UNIT_BITS   = 30;
   localparam int Q_W         = UNIT_BITS + 1;
   localparam int DIV_STAGES  = Q_W;
   localparam int NUM_W       = 64;
   localparam int DEN_W       = LEN_W;
   localparam int WIDE_W      = DEN_W + Q_W - 1;
   localparam int STIFF_W     = 17;
   localparam int STIFF_FRAC  = 16;
   localparam int EK_W        = LEN_W + 1;
   localparam int REST_W      = 31;
   localparam int MASS_W      = 32;
   localparam int WSUM_W      = MASS_W + 1;
   localparam int ERR_W       = LEN_W + 1;
   localparam int REQ_W       = 288;
   localparam int RSP_W       = 6 * POS_W;

   localparam logic [STIFF_W-1:0] STIFF_RESET = STIFF_W'(65536);

   typedef struct packed {
      logic                         v;
      logic [2:0][DIFF_W-1:0]       mag;
      logic [2:0]                   dpos;
      logic [MASS_W-1:0]            w1;
      logic [MASS_W-1:0]            w2;
      logic [WSUM_W-1:0]            wsum;
      logic [REST_W-1:0]            rest;
   } root_side_type;

   typedef struct packed {
      logic                         v;
      logic [EK_W-1:0]              ek;
      logic                         errpos;
      logic [2:0]                   dpos;
      logic                         degen;
      logic                         zero;
   } div_side_type;

   typedef struct packed {
      logic [5:0][POS_W-1:0]        delta;
      logic                         degen;
   } result_type;

   function automatic logic [POS_W-1:0] sat_signed(input logic [EK_W-1:0] mag,
                                                  input logic neg);
      logic [POS_W-1:0] res;
      if (neg) begin
         if (mag > EK_W'(64'h8000_0000)) res = 32'h8000_0000;
         else res = POS_W'(0) - mag[POS_W-1:0];
      end else begin
         if (mag > EK_W'(64'h7FFF_FFFF)) res = 32'h7FFF_FFFF;
         else res = mag[POS_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> rtl/distance_constraint_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance constraint projection
// Corrects two particle positions toward their rest distance in Q16.16.
// ----------------------------------------------------------------------------
// Throughput is one transaction per cycle while the output buffer has room,
// set by the fully pipelined square root (35 stages) and the five pipelined
// dividers (31 stages each).
// A two-entry output buffer keeps input open while one response waits.
// Reset clears all valid bits and sets the stiffness to one.
module distance_constraint_projection (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, rest_dist, inv_mass_a, inv_mass_b, pad
   input  logic [dcp_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // delta_a_x, delta_a_y, delta_a_z, delta_b_x, delta_b_y, delta_b_z
   output logic [dcp_pkg::RSP_W-1:0]     rsp_tdata,
   // degenerate
   output logic [0:0]                    rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dcp_pkg::STIFF_W-1:0]   csr_data
);
   import dcp_pkg::*;

   logic                   adv;
   logic [STIFF_W-1:0]     stiff_ff;

   // Stage 1: differences.
   logic                   s1_v_ff;
   logic [2:0][DIFF_W-1:0] s1_mag_ff, s1_mag_in;
   logic [2:0]             s1_dpos_ff, s1_dpos_in;
   logic [MASS_W-1:0]      s1_w1_ff, s1_w2_ff;
   logic [REST_W-1:0]      s1_rest_ff;

   // Stage 2: squares.
   logic                   s2_v_ff;
   logic [2:0][SQ_W-1:0]   s2_sq_ff;
   logic [2:0][DIFF_W-1:0] s2_mag_ff;
   logic [2:0]             s2_dpos_ff;
   logic [MASS_W-1:0]      s2_w1_ff, s2_w2_ff;
   logic [WSUM_W-1:0]      s2_wsum_ff;
   logic [REST_W-1:0]      s2_rest_ff;

   // Stage 3: sum of squares.
   logic [SUM_W-1:0]       s3_sum_ff;
   root_side_type          s3_side_ff;

   root_side_type          rside_ff [ROOT_STAGES];
   logic [LEN_W-1:0]       len;

   // Stage 4: error, scaled error and division operands.
   logic [2:0][NUM_W-1:0]  s4_nnum_ff, s4_nnum_in;
   logic [1:0][NUM_W-1:0]  s4_rnum_ff, s4_rnum_in;
   logic [LEN_W-1:0]       s4_len_ff;
   logic [WSUM_W-1:0]      s4_wsum_ff;
   div_side_type           s4_side_ff, s4_side_in;

   div_side_type           dside_ff [DIV_STAGES];
   logic [2:0][Q_W-1:0]    nq;
   logic [1:0][Q_W-1:0]    rq;

   // Stage 5 and 6: products.
   logic [2:0][EK_W-1:0]   s5_g_ff, s5_g_in;
   logic [1:0][Q_W-1:0]    s5_r_ff;
   div_side_type           s5_side_ff;
   logic [5:0][EK_W-1:0]   s6_m_ff, s6_m_in;
   div_side_type           s6_side_ff;

   result_type             res;
   result_type             out_ff;
   result_type             skid_ff;
   logic                   out_v_ff;
   logic                   skid_v_ff;

   assign adv        = !skid_v_ff;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= STIFF_RESET;
      end else if (csr_valid) begin
         stiff_ff <= csr_data;
      end
   end

   always_comb begin
      logic signed [DIFF_W-1:0] d;
      for (int i = 0; i < 3; i++) begin
         d = DIFF_W'($signed(req_tdata[i*POS_W +: POS_W]))
           - DIFF_W'($signed(req_tdata[(i+3)*POS_W +: POS_W]));
         s1_mag_in[i]  = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
         s1_dpos_in[i] = !d[DIFF_W-1] && (d != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_side_ff.v <= 1'b0;
      end else if (adv) begin
         s1_v_ff         <= req_tvalid;
         s2_v_ff         <= s1_v_ff;
         s3_side_ff.v    <= s2_v_ff;
         s3_side_ff.mag  <= s2_mag_ff;
         s3_side_ff.dpos <= s2_dpos_ff;
         s3_side_ff.w1   <= s2_w1_ff;
         s3_side_ff.w2   <= s2_w2_ff;
         s3_side_ff.wsum <= s2_wsum_ff;
         s3_side_ff.rest <= s2_rest_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mag_ff  <= s1_mag_in;
         s1_dpos_ff <= s1_dpos_in;
         s1_rest_ff <= req_tdata[6*POS_W +: REST_W];
         s1_w1_ff   <= req_tdata[6*POS_W+REST_W +: MASS_W];
         s1_w2_ff   <= req_tdata[6*POS_W+REST_W+MASS_W +: MASS_W];

         for (int i = 0; i < 3; i++) begin
            s2_sq_ff[i] <= SQ_W'(s1_mag_ff[i]) * SQ_W'(s1_mag_ff[i]);
         end
         s2_mag_ff  <= s1_mag_ff;
         s2_dpos_ff <= s1_dpos_ff;
         s2_w1_ff   <= s1_w1_ff;
         s2_w2_ff   <= s1_w2_ff;
         s2_wsum_ff <= WSUM_W'(s1_w1_ff) + WSUM_W'(s1_w2_ff);
         s2_rest_ff <= s1_rest_ff;

         s3_sum_ff  <= SUM_W'(s2_sq_ff[0]) + SUM_W'(s2_sq_ff[1]) + SUM_W'(s2_sq_ff[2]);
      end
   end

   dcp_sqrt u_sqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (s3_sum_ff),
      .root     (len)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_STAGES; k++) rside_ff[k].v <= 1'b0;
      end else if (adv) begin
         rside_ff[0] <= s3_side_ff;
         for (int k = 1; k < ROOT_STAGES; k++) rside_ff[k] <= rside_ff[k-1];
      end
   end

   always_comb begin
      root_side_type             rs;
      logic signed [ERR_W-1:0]   err;
      logic [LEN_W-1:0]          emag;
      logic [LEN_W+STIFF_W-1:0]  ekp;
      rs   = rside_ff[ROOT_STAGES-1];
      err  = $signed({1'b0, len}) - $signed(ERR_W'(rs.rest));
      emag = err[ERR_W-1] ? LEN_W'(-err) : LEN_W'(err);
      ekp  = (LEN_W+STIFF_W)'(emag) * (LEN_W+STIFF_W)'(stiff_ff)
           + (LEN_W+STIFF_W)'(1 << (STIFF_FRAC-1));
      s4_side_in.v      = rs.v;
      s4_side_in.ek     = EK_W'(ekp >> STIFF_FRAC);
      s4_side_in.errpos = !err[ERR_W-1] && (err != '0);
      s4_side_in.dpos   = rs.dpos;
      s4_side_in.degen  = (len == '0) || (rs.wsum == '0);
      s4_side_in.zero   = (err == '0);
      for (int i = 0; i < 3; i++) begin
         s4_nnum_in[i] = (NUM_W'(rs.mag[i]) << UNIT_BITS) + NUM_W'(len >> 1);
      end
      s4_rnum_in[0] = (NUM_W'(rs.w1) << UNIT_BITS) + NUM_W'(rs.wsum >> 1);
      s4_rnum_in[1] = (NUM_W'(rs.w2) << UNIT_BITS) + NUM_W'(rs.wsum >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_side_ff.v <= 1'b0;
      end else if (adv) begin
         s4_side_ff <= s4_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_nnum_ff <= s4_nnum_in;
         s4_rnum_ff <= s4_rnum_in;
         s4_len_ff  <= len;
         s4_wsum_ff <= rside_ff[ROOT_STAGES-1].wsum;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_ndiv
      dcp_div u_div (
         .clock  (clock),
         .enable (adv),
         .num    (s4_nnum_ff[i]),
         .den    (s4_len_ff),
         .quo    (nq[i])
      );
   end

   for (genvar j = 0; j < 2; j++) begin : g_rdiv
      dcp_div u_div (
         .clock  (clock),
         .enable (adv),
         .num    (s4_rnum_ff[j]),
         .den    (DEN_W'(s4_wsum_ff)),
         .quo    (rq[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) dside_ff[k].v <= 1'b0;
         s5_side_ff.v <= 1'b0;
         s6_side_ff.v <= 1'b0;
      end else if (adv) begin
         dside_ff[0] <= s4_side_ff;
         for (int k = 1; k < DIV_STAGES; k++) dside_ff[k] <= dside_ff[k-1];
         s5_side_ff <= dside_ff[DIV_STAGES-1];
         s6_side_ff <= s5_side_ff;
      end
   end

   always_comb begin
      logic [EK_W+Q_W-1:0] p;
      for (int i = 0; i < 3; i++) begin
         p = (EK_W+Q_W)'(dside_ff[DIV_STAGES-1].ek) * (EK_W+Q_W)'(nq[i])
           + (EK_W+Q_W)'(1 << (UNIT_BITS-1));
         s5_g_in[i] = EK_W'(p >> UNIT_BITS);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 2; j++) begin
            p = (EK_W+Q_W)'(s5_g_ff[i]) * (EK_W+Q_W)'(s5_r_ff[j])
              + (EK_W+Q_W)'(1 << (UNIT_BITS-1));
            s6_m_in[j*3+i] = EK_W'(p >> UNIT_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_g_ff <= s5_g_in;
         s5_r_ff <= rq;
         s6_m_ff <= s6_m_in;
      end
   end

   always_comb begin
      logic same;
      res.degen = s6_side_ff.degen;
      for (int i = 0; i < 3; i++) begin
         same = (s6_side_ff.errpos == s6_side_ff.dpos[i]);
         if (s6_side_ff.degen || s6_side_ff.zero) begin
            res.delta[i]   = '0;
            res.delta[3+i] = '0;
         end else begin
            res.delta[i]   = sat_signed(s6_m_ff[i], same);
            res.delta[3+i] = sat_signed(s6_m_ff[3+i], !same);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= s6_side_ff.v;
         end
      end else if (adv && s6_side_ff.v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_ff <= skid_v_ff ? skid_ff : res;
      end else if (adv) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = out_ff.delta;
   assign rsp_tuser[0] = out_ff.degen;

   assert property (@(posedge clock) disable iff (reset) skid_v_ff |-> out_v_ff)
      else $error("Skid buffer holds a response while the output is empty.");

   assert property (@(posedge clock) disable iff (reset)
                    (out_v_ff && out_ff.degen) |-> (out_ff.delta == '0))
      else $error("Degenerate response carries nonzero corrections.");

   assert property (@(posedge clock) disable iff (reset)
                    (out_v_ff && !rsp_tready && !skid_v_ff && s6_side_ff.v) |=> skid_v_ff)
      else $error("Pipeline result was dropped during an output stall.");

   assert property (@(posedge clock) reset |=> (!out_v_ff && !skid_v_ff))
      else $error("Output valid bits not cleared by reset.");

endmodule

>>> rtl/dcp_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Resolves one root bit per stage with a restoring digit recurrence.
// ----------------------------------------------------------------------------
module dcp_sqrt (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [dcp_pkg::SUM_W-1:0]  radicand,
   output logic [dcp_pkg::LEN_W-1:0]  root
);
   import dcp_pkg::*;

   logic [RAD_W-1:0] rad_ff  [ROOT_STAGES];
   logic [REM_W-1:0] rem_ff  [ROOT_STAGES];
   logic [LEN_W-1:0] root_ff [ROOT_STAGES];

   for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
      logic [RAD_W-1:0] rad_i;
      logic [REM_W-1:0] rem_i;
      logic [LEN_W-1:0] root_i;
      logic [REM_W+1:0] r2;
      logic [REM_W+1:0] trial;
      logic [RAD_W-1:0] rad_in;
      logic [REM_W-1:0] rem_in;
      logic [LEN_W-1:0] root_in;

      if (k == 0) begin : g_head
         assign rad_i  = {{(RAD_W-SUM_W){1'b0}}, radicand};
         assign rem_i  = '0;
         assign root_i = '0;
      end else begin : g_body
         assign rad_i  = rad_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
      end

      always_comb begin
         r2     = {rem_i, rad_i[RAD_W-1 -: 2]};
         trial  = {2'b00, root_i, 2'b01};
         rad_in = rad_i << 2;
         if (r2 >= trial) begin
            rem_in  = REM_W'(r2 - trial);
            root_in = {root_i[LEN_W-2:0], 1'b1};
         end else begin
            rem_in  = r2[REM_W-1:0];
            root_in = {root_i[LEN_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_STAGES-1];

endmodule

>>> rtl/dcp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division that resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module dcp_div (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [dcp_pkg::NUM_W-1:0]  num,
   input  logic [dcp_pkg::DEN_W-1:0]  den,
   output logic [dcp_pkg::Q_W-1:0]    quo
);
   import dcp_pkg::*;

   logic [NUM_W-1:0] n_ff [DIV_STAGES];
   logic [DEN_W-1:0] d_ff [DIV_STAGES];
   logic [Q_W-1:0]   q_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [NUM_W-1:0]  n_i;
      logic [DEN_W-1:0]  d_i;
      logic [Q_W-1:0]    q_i;
      logic [WIDE_W-1:0] ne;
      logic [WIDE_W-1:0] dsh;
      logic              ge;
      logic [NUM_W-1:0]  n_in;

      if (k == 0) begin : g_head
         assign n_i = num;
         assign d_i = den;
         assign q_i = '0;
      end else begin : g_body
         assign n_i = n_ff[k-1];
         assign d_i = d_ff[k-1];
         assign q_i = q_ff[k-1];
      end

      always_comb begin
         ne   = {{(WIDE_W-NUM_W){1'b0}}, n_i};
         dsh  = {{(WIDE_W-DEN_W){1'b0}}, d_i} << (Q_W - 1 - k);
         ge   = (ne >= dsh);
         n_in = ge ? NUM_W'(ne - dsh) : n_i;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            n_ff[k] <= n_in;
            d_ff[k] <= d_i;
            q_ff[k] <= {q_i[Q_W-2:0], ge};
         end
      end
   end

   assign quo = q_ff[DIV_STAGES-1];

endmodule

>>> test/distance_constraint_projection_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance constraint projection testbench
// Streams directed and random constraints through the block, computes the
// expected corrections with an independent fixed-point predictor and checks
// every response field by field, under random idling, stalls and stiffness.
// ----------------------------------------------------------------------------
module distance_constraint_projection_test;
   import dcp_pkg::*;

   typedef struct packed {
      logic [31:0] inv_b;
      logic [31:0] inv_a;
      logic [30:0] rest;
      logic [31:0] bz;
      logic [31:0] by;
      logic [31:0] bx;
      logic [31:0] az;
      logic [31:0] ay;
      logic [31:0] ax;
   } constraint_type;

   typedef struct packed {
      logic [5:0][31:0] delta;
      logic             degen;
   } correction_type;

   typedef struct {
      constraint_type item;
      bit             typed;
      correction_type want;
   } directed_row_type;

   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SMIN = 32'h8000_0000;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;
   logic [0:0]          rsp_tuser;
   logic                csr_valid;
   logic                csr_ready;
   logic [STIFF_W-1:0]  csr_data;

   correction_type      pending_corrections[$];
   logic [16:0]         stiffness_now;
   int                  errors;
   int                  ready_mode;
   int                  long_holds_asked;
   int                  long_holds_done;
   int                  hold_left;

   distance_constraint_projection dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [127:0] round_shift(logic [127:0] p, int sh);
      return (p + (128'd1 << (sh - 1))) >> sh;
   endfunction

   function automatic logic [31:0] saturate(logic [127:0] mag, logic neg);
      if (neg) begin
         if (mag > 128'h8000_0000) return SMIN;
         return 32'd0 - mag[31:0];
      end
      if (mag > 128'h7FFF_FFFF) return SMAX;
      return mag[31:0];
   endfunction

   function automatic logic [34:0] floor_root(logic [69:0] s);
      logic [34:0] r;
      logic [69:0] c;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
         c = {35'd0, r | (35'd1 << b)};
         if (c * c <= s) r = c[34:0];
      end
      return r;
   endfunction

   function automatic correction_type project_constraint(constraint_type c, logic [16:0] k);
      logic signed [32:0] d[3];
      logic [69:0]        m[3];
      logic [69:0]        ssum;
      logic [34:0]        len;
      logic signed [36:0] err;
      logic [127:0]       ek, ra, rb, wsum, n, g;
      logic               same;
      correction_type     r;
      d[0] = $signed({c.ax[31], c.ax}) - $signed({c.bx[31], c.bx});
      d[1] = $signed({c.ay[31], c.ay}) - $signed({c.by[31], c.by});
      d[2] = $signed({c.az[31], c.az}) - $signed({c.bz[31], c.bz});
      ssum = '0;
      for (int i = 0; i < 3; i++) begin
         m[i] = d[i] < 0 ? 70'(-d[i]) : 70'(d[i]);
         ssum += m[i] * m[i];
      end
      len = floor_root(ssum);
      wsum = 128'(c.inv_a) + 128'(c.inv_b);
      r = '0;
      if (len == 0 || wsum == 0) begin
         r.degen = 1'b1;
         return r;
      end
      err = $signed({2'b00, len}) - $signed({6'd0, c.rest});
      if (err == 0) return r;
      ek = round_shift(128'(err < 0 ? -err : err) * 128'(k), 16);
      ra = ((128'(c.inv_a) << 30) + wsum / 2) / wsum;
      rb = ((128'(c.inv_b) << 30) + wsum / 2) / wsum;
      for (int i = 0; i < 3; i++) begin
         n = ((128'(m[i]) << 30) + 128'(len) / 2) / 128'(len);
         g = round_shift(ek * n, 30);
         same = (err > 0) == (d[i] > 0);
         r.delta[i] = saturate(round_shift(g * ra, 30), same);
         r.delta[3 + i] = saturate(round_shift(g * rb, 30), !same);
      end
      return r;
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return SMAX;
         1: return SMIN;
         2: return 32'd0;
         3: return 32'hFFFF_FFFF;
         default: return 32'd1;
      endcase
   endfunction

   function automatic constraint_type random_constraint();
      constraint_type c;
      int             kind;
      kind = $urandom_range(0, 9);
      c = 287'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom});
      if (kind < 5) begin
         c.ax = $signed($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000;
         c.ay = $signed($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000;
         c.az = $signed($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000;
         c.bx = c.ax + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
         c.by = c.ay + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
         c.bz = c.az + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
         c.rest = 31'($urandom_range(0, 32'h3_0000));
         c.inv_a = $urandom_range(0, 7) == 0 ? 32'd0 : $urandom_range(1, 32'h10_0000);
         c.inv_b = $urandom_range(0, 7) == 0 ? 32'd0 : $urandom_range(1, 32'h10_0000);
      end else if (kind < 7) begin
         c.ax = pick_extreme(); c.ay = pick_extreme(); c.az = pick_extreme();
         c.bx = pick_extreme(); c.by = pick_extreme(); c.bz = pick_extreme();
         c.rest = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
         c.inv_a = pick_extreme();
         c.inv_b = pick_extreme();
      end else if (kind == 7) begin
         c.bx = c.ax; c.by = c.ay; c.bz = c.az;
      end else if (kind == 8) begin
         c.ay = c.by; c.az = c.bz;
         c.ax = c.bx + $urandom_range(0, 32'h3FFF_FFFF);
         c.rest = 31'(c.ax - c.bx);
      end
      return c;
   endfunction

   function automatic constraint_type make_constraint(logic [31:0] ax, logic [31:0] ay,
         logic [31:0] az, logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
         logic [30:0] rest, logic [31:0] wa, logic [31:0] wb);
      constraint_type c;
      c.ax = ax; c.ay = ay; c.az = az; c.bx = bx; c.by = by; c.bz = bz;
      c.rest = rest; c.inv_a = wa; c.inv_b = wb;
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic send_constraint(constraint_type c, int burst_left);
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'(c);
      do @(posedge clock); while (!req_tready);
      pending_corrections.push_back(project_constraint(c, stiffness_now));
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic run_random(int count);
      int burst;
      burst = $urandom_range(0, 12);
      for (int i = 0; i < count; i++) begin
         send_constraint(random_constraint(), burst);
         burst = burst == 0 ? $urandom_range(0, 12) : burst - 1;
      end
   endtask

   task automatic write_stiffness(logic [16:0] k);
      req_tvalid <= 1'b0;
      while (pending_corrections.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      stiffness_now = k;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         long_holds_done <= 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (long_holds_done != long_holds_asked) begin
         rsp_tready <= 1'b0;
         hold_left <= 400;
         long_holds_done <= long_holds_asked;
      end else begin
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 3) != 0;
            default: rsp_tready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   always @(posedge clock) begin
      correction_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_corrections.size() == 0) begin
            $display("unexpected transaction at %0t", $realtime);
            errors++;
         end else begin
            want = pending_corrections.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (rsp_tdata[32 * i +: 32] !== want.delta[i]) begin
                  report_mismatch($sformatf("delta[%0d]", i), rsp_tdata[32 * i +: 32],
                                  want.delta[i]);
               end
            end
            if (rsp_tuser[0] !== want.degen) begin
               report_mismatch("degenerate", 32'(rsp_tuser[0]), 32'(want.degen));
            end
         end
      end
   end

   initial begin
      #6_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      correction_type   zero;
      correction_type   unit;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      errors = 0;
      ready_mode = 0;
      long_holds_asked = 0;
      stiffness_now = 17'd65536;
      zero = '0;
      unit = '0;
      unit.delta[0] = 32'hFFFF_8000;
      unit.delta[3] = 32'h0000_8000;

      row.typed = 1'b1;
      row.want = zero;
      row.want.degen = 1'b1;
      row.item = make_constraint(ONE, ONE, ONE, ONE, ONE, ONE, 31'd5, ONE, ONE);
      rows.push_back(row);
      row.item = make_constraint(SMAX, SMIN, 0, SMAX, SMIN, 0, 31'h7FFF_FFFF, SMAX, 0);
      rows.push_back(row);
      row.item = make_constraint(ONE, 0, 0, 0, 0, 0, 31'd0, 0, 0);
      rows.push_back(row);
      row.item = make_constraint(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, 31'd0, 0, 0);
      rows.push_back(row);
      row.want = zero;
      row.item = make_constraint(3 * ONE, 0, 0, 0, 0, 0, 31'(3 * ONE), ONE, ONE);
      rows.push_back(row);
      row.item = make_constraint(0, 0, -5 * ONE, 0, 0, 0, 31'(5 * ONE), 0, 32'hFFFF_FFFF);
      rows.push_back(row);
      row.want = unit;
      row.item = make_constraint(ONE, 0, 0, 0, 0, 0, 31'd0, ONE, ONE);
      rows.push_back(row);
      row.typed = 1'b0;
      row.item = make_constraint(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, 31'd0, SMAX, 1);
      rows.push_back(row);
      row.item = make_constraint(SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, 31'h7FFF_FFFF,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      rows.push_back(row);
      row.item = make_constraint(0, ONE, 0, 0, 0, 0, 31'h7FFF_FFFF, 1, 32'hFFFF_FFFF);
      rows.push_back(row);
      row.item = make_constraint(0, 0, 0, 1, 0, 0, 31'd3, ONE, 0);
      rows.push_back(row);
      row.item = make_constraint(-2 * ONE, 7 * ONE, 3, ONE, -ONE, 99, 31'(ONE), 5, 9);
      rows.push_back(row);
      row.item = make_constraint(SMIN, 0, 0, SMAX, 0, 0, 31'h7FFF_FFFF, 0, ONE);
      rows.push_back(row);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_constraint(rows[i].item, 1);
         if (rows[i].typed) pending_corrections[$] = rows[i].want;
      end

      ready_mode = 1;
      run_random(100);
      long_holds_asked = 1;
      run_random(120);
      write_stiffness(17'd0);
      ready_mode = 2;
      run_random(80);
      write_stiffness(17'h1_FFFF);
      ready_mode = 0;
      run_random(90);
      write_stiffness(17'($urandom_range(1, 65535)));
      ready_mode = 1;
      run_random(80);
      write_stiffness(17'd65536);
      long_holds_asked = 2;
      run_random(80);
      req_tvalid <= 1'b0;

      while (pending_corrections.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
